// ===== rtl/assert_macros.svh =====
// assertion macros shared by the heading pipeline modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain concurrent check, disabled while reset is high
`define DTD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// consequent implies that the antecedent held a fixed number of cycles ago
`define DTD_ASSERT_PAST(lbl, clk, rst, cons, ante, n, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cons) |-> $past((ante), n)) \
      else $error(msg);

`endif

// ===== rtl/dtd_pkg.sv =====
// shared constants, beat type and arctangent table for the heading pipeline
package dtd_pkg;

   localparam int COORD_WIDTH   = 16;
   localparam int CORDIC_STAGES = 24;

   localparam int FRAC_BITS = 24;
   localparam int PRE_SHIFT = 60 - COORD_WIDTH;
   localparam int DIFF_W    = COORD_WIDTH + 1;
   localparam int XY_W      = DIFF_W + PRE_SHIFT + 2;
   localparam int Z_W       = FRAC_BITS + 11;
   localparam int SHIFT_W   = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
   localparam int HEAD_W    = 9;

   localparam logic signed [Z_W-1:0] Z_180  = Z_W'(180) <<< FRAC_BITS;
   localparam logic signed [Z_W-1:0] Z_360  = Z_W'(360) <<< FRAC_BITS;
   localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(1) <<< (FRAC_BITS - 1);

   localparam logic [HEAD_W-1:0] HEAD_0   = HEAD_W'(0);
   localparam logic [HEAD_W-1:0] HEAD_90  = HEAD_W'(90);
   localparam logic [HEAD_W-1:0] HEAD_180 = HEAD_W'(180);
   localparam logic [HEAD_W-1:0] HEAD_270 = HEAD_W'(270);
   localparam logic [HEAD_W-1:0] HEAD_360 = HEAD_W'(360);

   localparam logic [63:0] E10      = 64'd10000000000;
   localparam logic [63:0] E10_HALF = 64'd5000000000;
   localparam logic [63:0] TAIL_E10 = 64'd572957795131;
   localparam logic [63:0] Q_ONE    = 64'd16777216;

   // one pipeline beat; special beats carry a finished heading
   typedef struct packed {
      logic                    valid;
      logic                    special;
      logic [HEAD_W-1:0]       spec_heading;
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [Z_W-1:0]   z;
   } beat_type;

   // atan(2^-i) in degrees, scaled by 1e10
   function automatic logic [63:0] atan_e10(input int i);
      logic [63:0] v;
      case (i)
         0:       v = 64'd450000000000;
         1:       v = 64'd265650511771;
         2:       v = 64'd140362434679;
         3:       v = 64'd71250163489;
         4:       v = 64'd35763343750;
         5:       v = 64'd17899106082;
         6:       v = 64'd8951737102;
         7:       v = 64'd4476141709;
         8:       v = 64'd2238105004;
         9:       v = 64'd1119056771;
         10:      v = 64'd559528919;
         11:      v = 64'd279764526;
         12:      v = 64'd139882271;
         13:      v = 64'd69941137;
         default: v = 64'd0;
      endcase
      return v;
   endfunction

   // atan(2^-i) in Q.24 degrees, rounded to nearest; small angles use 180/pi * 2^-i
   function automatic logic [Z_W-1:0] atan_q(input int i);
      logic [63:0] q;
      if (i < 14) begin
         q = (atan_e10(i) * Q_ONE + E10_HALF) / E10;
      end else begin
         q = (((TAIL_E10 * Q_ONE) >> i) + E10_HALF) / E10;
      end
      return q[Z_W-1:0];
   endfunction

endpackage

// ===== rtl/dtd_prep.sv =====
// difference vector, half-plane fold and scaling ahead of the cordic row
module dtd_prep
   import dtd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [COORD_WIDTH-1:0] from_x,
   input  logic [COORD_WIDTH-1:0] from_y,
   input  logic [COORD_WIDTH-1:0] to_x,
   input  logic [COORD_WIDTH-1:0] to_y,
   output beat_type               beat_out
);

   `include "assert_macros.svh"

   logic signed [DIFF_W-1:0] dx;
   logic signed [DIFF_W-1:0] dy;
   logic signed [DIFF_W-1:0] fx;
   logic signed [DIFF_W-1:0] fy;
   beat_type                 beat_in;
   beat_type                 beat_ff;

   always_comb begin
      dx = $signed({to_x[COORD_WIDTH-1], to_x}) - $signed({from_x[COORD_WIDTH-1], from_x});
      dy = $signed({to_y[COORD_WIDTH-1], to_y}) - $signed({from_y[COORD_WIDTH-1], from_y});
      fx = dx[DIFF_W-1] ? -dx : dx;
      fy = dx[DIFF_W-1] ? -dy : dy;

      beat_in.valid        = accept && !reset;
      beat_in.special      = 1'b0;
      beat_in.spec_heading = HEAD_0;
      beat_in.x            = XY_W'(fx) <<< PRE_SHIFT;
      beat_in.y            = XY_W'(fy) <<< PRE_SHIFT;
      beat_in.z            = dx[DIFF_W-1] ? Z_180 : '0;

      // axis-aligned vectors and the null vector bypass the rotation
      if (dy == '0) begin
         beat_in.special      = 1'b1;
         beat_in.spec_heading = dx[DIFF_W-1] ? HEAD_180 : HEAD_0;
      end else if (dx == '0) begin
         beat_in.special      = 1'b1;
         beat_in.spec_heading = dy[DIFF_W-1] ? HEAD_270 : HEAD_90;
      end
      if (beat_in.special) begin
         beat_in.x = '0;
         beat_in.y = '0;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign beat_out = beat_ff;

   `DTD_ASSERT(a_null_vector_zero, clock, reset,
      accept && (to_x == from_x) && (to_y == from_y)
         |=> beat_ff.special && (beat_ff.spec_heading == HEAD_0),
      "null vector did not map to heading zero")

endmodule

// ===== rtl/dtd_cell.sv =====
// one cordic vectoring step with its pipeline register
module dtd_cell
   import dtd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [SHIFT_W-1:0]    shift,
   input  logic signed [Z_W-1:0] angle,
   input  beat_type              beat_in,
   output beat_type              beat_out
);

   `include "assert_macros.svh"

   logic signed [XY_W-1:0] xs;
   logic signed [XY_W-1:0] ys;
   logic                   y_pos;
   beat_type               next_in;
   beat_type               beat_ff;

   always_comb begin
      xs      = beat_in.x >>> shift;
      ys      = beat_in.y >>> shift;
      y_pos   = !beat_in.y[XY_W-1] && (beat_in.y != '0);
      next_in = beat_in;
      next_in.valid = beat_in.valid && !reset;
      if (y_pos) begin
         next_in.x = beat_in.x + ys;
         next_in.y = beat_in.y - xs;
         next_in.z = beat_in.z + angle;
      end else begin
         next_in.x = beat_in.x - ys;
         next_in.y = beat_in.y + xs;
         next_in.z = beat_in.z - angle;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= next_in;
   end

   assign beat_out = beat_ff;

   // x only grows in vectoring mode, so it never turns negative
   `DTD_ASSERT(a_x_nonneg, clock, reset,
      beat_in.valid && !beat_in.special && !beat_in.x[XY_W-1] |=> !beat_ff.x[XY_W-1],
      "cordic x went negative")

endmodule

// ===== rtl/dtd_round.sv =====
// angle wrap, round half up and clamp to whole degrees
module dtd_round
   import dtd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  beat_type          beat_in,
   output logic              rsp_valid,
   output logic [HEAD_W-1:0] rsp_heading_degrees
);

   localparam int Q_W = Z_W - FRAC_BITS;

   logic signed [Z_W-1:0] zw;
   logic signed [Z_W-1:0] zr;
   logic [Q_W-1:0]        q;
   logic [HEAD_W-1:0]     heading_in;
   logic [HEAD_W-1:0]     heading_ff;
   logic                  valid_ff;

   always_comb begin
      zw = beat_in.z[Z_W-1] ? beat_in.z + Z_360 : beat_in.z;
      if (zw[Z_W-1]) begin
         zw = '0;
      end
      zr = zw + Z_HALF;
      q  = zr[Z_W-1:FRAC_BITS];
      if (beat_in.special) begin
         heading_in = beat_in.spec_heading;
      end else if (q > Q_W'(HEAD_360)) begin
         heading_in = HEAD_360;
      end else begin
         heading_in = q[HEAD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      heading_ff <= heading_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= beat_in.valid;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_heading_degrees = heading_ff;

endmodule

// ===== rtl/direction_to_degrees_core.sv =====
// heading from one point to another in whole degrees, cordic vectoring pipeline
// an accepted request passes through the prep register, one register per cordic cell and
// the round register, in that order, before its heading is shown with rsp_valid
// throughput: one beat per clock unless busy; every cell register advances each cycle, nothing stalls
// reset: synchronous, clears the valid bits of the row; busy is high for the cycle after reset
// results are shown for one cycle on rsp_valid and cannot be held off by the receiver
module direction_to_degrees_core
   import dtd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [COORD_WIDTH-1:0] req_from_x,
   input  logic [COORD_WIDTH-1:0] req_from_y,
   input  logic [COORD_WIDTH-1:0] req_to_x,
   input  logic [COORD_WIDTH-1:0] req_to_y,
   output logic                   rsp_valid,
   output logic [HEAD_W-1:0]      rsp_heading_degrees
);

   `include "assert_macros.svh"

   // accept edge to the edge at which the result beat is sampled
   localparam int LAT = CORDIC_STAGES + 2;

   logic     busy_ff;
   logic     accept;
   beat_type chain [CORDIC_STAGES+1];

   // busy only covers the cycle right after reset; otherwise every clock with start takes a beat
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // difference vector, fold into the right half plane, scale up
   dtd_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .from_x   (req_from_x),
      .from_y   (req_from_y),
      .to_x     (req_to_x),
      .to_y     (req_to_y),
      .beat_out (chain[0])
   );

   // row of vectoring cells, each with a fixed shift and arctangent constant
   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
      localparam logic [SHIFT_W-1:0]    SHIFT_K = SHIFT_W'(k);
      localparam logic signed [Z_W-1:0] ANGLE_K = atan_q(k);

      dtd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (SHIFT_K),
         .angle    (ANGLE_K),
         .beat_in  (chain[k]),
         .beat_out (chain[k+1])
      );
   end

   // wrap into a full turn and round to whole degrees
   dtd_round u_round (
      .clock               (clock),
      .reset               (reset),
      .beat_in             (chain[CORDIC_STAGES]),
      .rsp_valid           (rsp_valid),
      .rsp_heading_degrees (rsp_heading_degrees)
   );

   // every result beat traces back to an earlier accepted request
   `DTD_ASSERT_PAST(a_rsp_has_req, clock, reset, rsp_valid, accept, LAT,
      "result beat without a matching request")

   // a heading above a full turn must never leave the block
   `DTD_ASSERT(a_heading_range, clock, reset,
      chain[CORDIC_STAGES].valid |=> rsp_valid && (rsp_heading_degrees <= HEAD_360),
      "result strobe missing or heading out of range")

endmodule

// ===== verif/direction_to_degrees_core_test.sv =====
// self-checking testbench for the point-to-point heading pipeline
module direction_to_degrees_core_test
   import dtd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // pipeline depth plus margin, used only for the final quiet period
   localparam int PIPE_DEPTH     = CORDIC_STAGES + 2;
   localparam int DRAIN_CYCLES   = 2 * PIPE_DEPTH;
   // cycles with no beat in or out before the run is called hung
   localparam int HANG_LIMIT     = 1000;
   localparam int RANDOM_BEATS   = 1130;
   localparam int BURST_LEN      = 40;
   localparam int MAX_GAP        = 6;
   localparam int DIRECTED_ROWS  = 21;

   // predictor constants in 2^-(FRAC_BITS) degree units and coordinate pre-scale
   localparam longint DEG_ONE    = 64'sd1 <<< FRAC_BITS;
   localparam longint DEG_HALF   = 64'sd1 <<< (FRAC_BITS - 1);
   localparam longint ANGLE_PRE  = 64'sd1 <<< PRE_SHIFT;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] from_x;
      logic signed [COORD_WIDTH-1:0] from_y;
      logic signed [COORD_WIDTH-1:0] to_x;
      logic signed [COORD_WIDTH-1:0] to_y;
   } point_pair_type;

   // one directed beat; fixed rows carry a heading that is obvious by hand
   typedef struct packed {
      point_pair_type    pair;
      bit                fixed;
      logic [HEAD_W-1:0] heading;
   } heading_row_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [COORD_WIDTH-1:0] req_from_x;
   logic [COORD_WIDTH-1:0] req_from_y;
   logic [COORD_WIDTH-1:0] req_to_x;
   logic [COORD_WIDTH-1:0] req_to_y;
   logic                   rsp_valid;
   logic [HEAD_W-1:0]      rsp_heading_degrees;

   // headings still owed by the pipeline, oldest first
   logic [HEAD_W-1:0] pending_headings [$];
   int                error_count = 0;
   int                quiet_cycles = 0;

   // directed rows: equal points, both axes, extremes, the wrap to a full turn,
   // the four diagonals and plain vectors in each quadrant
   heading_row_type directed_rows [DIRECTED_ROWS] = '{
      // equal points give 0
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, HEAD_0},
      '{'{16'sd1234, -16'sd77, 16'sd1234, -16'sd77}, 1'b1, HEAD_0},
      '{'{16'h7fff, 16'h8000, 16'h7fff, 16'h8000}, 1'b1, HEAD_0},
      // horizontal, widest span both ways
      '{'{16'h8000, 16'sd5, 16'h7fff, 16'sd5}, 1'b1, HEAD_0},
      '{'{16'h7fff, -16'sd9, 16'h8000, -16'sd9}, 1'b1, HEAD_180},
      // vertical, widest span both ways
      '{'{16'sd3, 16'h8000, 16'sd3, 16'h7fff}, 1'b1, HEAD_90},
      '{'{-16'sd3, 16'h7fff, -16'sd3, 16'h8000}, 1'b1, HEAD_270},
      // a hair below a full turn rounds up to 360
      '{'{16'h8000, 16'sd0, 16'h7fff, -16'sd1}, 1'b1, HEAD_360},
      // a hair above 0, and both sides of 180
      '{'{16'h8000, 16'sd0, 16'h7fff, 16'sd1}, 1'b1, HEAD_0},
      '{'{16'h7fff, 16'sd0, 16'h8000, 16'sd1}, 1'b1, HEAD_180},
      '{'{16'h7fff, 16'sd0, 16'h8000, -16'sd1}, 1'b1, HEAD_180},
      // corner to corner diagonals
      '{'{16'h8000, 16'h8000, 16'h7fff, 16'h7fff}, 1'b0, HEAD_0},
      '{'{16'h7fff, 16'h7fff, 16'h8000, 16'h8000}, 1'b0, HEAD_0},
      '{'{16'h8000, 16'h7fff, 16'h7fff, 16'h8000}, 1'b0, HEAD_0},
      '{'{16'h7fff, 16'h8000, 16'h8000, 16'h7fff}, 1'b0, HEAD_0},
      // short vectors, steep and shallow ones
      '{'{16'sd0, 16'sd0, 16'sd1, 16'sd2}, 1'b0, HEAD_0},
      '{'{16'sd0, 16'sd0, -16'sd2, 16'sd1}, 1'b0, HEAD_0},
      '{'{16'sd0, 16'h7fff, 16'sd1, 16'h8000}, 1'b0, HEAD_0},
      '{'{16'sd0, 16'sd0, 16'h7fff, 16'sd1}, 1'b0, HEAD_0},
      '{'{16'sd100, 16'sd200, -16'sd300, -16'sd50}, 1'b0, HEAD_0},
      '{'{-16'sd1, -16'sd1, 16'sd0, 16'sd0}, 1'b0, HEAD_0}
   };

   direction_to_degrees_core dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_from_x          (req_from_x),
      .req_from_y          (req_from_y),
      .req_to_x            (req_to_x),
      .req_to_y            (req_to_y),
      .rsp_valid           (rsp_valid),
      .rsp_heading_degrees (rsp_heading_degrees)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // atan(2^-i) in q24 degrees, rounded to nearest; past i = 13 the small-angle
   // form 180/pi * 2^-i is used
   function automatic longint cordic_step_angle(input int i);
      logic [63:0] e10;
      logic [63:0] q;
      case (i)
         0:       e10 = 64'd450000000000;
         1:       e10 = 64'd265650511771;
         2:       e10 = 64'd140362434679;
         3:       e10 = 64'd71250163489;
         4:       e10 = 64'd35763343750;
         5:       e10 = 64'd17899106082;
         6:       e10 = 64'd8951737102;
         7:       e10 = 64'd4476141709;
         8:       e10 = 64'd2238105004;
         9:       e10 = 64'd1119056771;
         10:      e10 = 64'd559528919;
         11:      e10 = 64'd279764526;
         12:      e10 = 64'd139882271;
         13:      e10 = 64'd69941137;
         default: e10 = 64'd0;
      endcase
      // unsigned 64-bit math: the tail product does not fit a signed longint
      if (i < 14) begin
         q = (e10 * 64'd16777216 + 64'd5000000000) / 64'd10000000000;
      end else begin
         q = (((64'd572957795131 * 64'd16777216) >> i) + 64'd5000000000)
             / 64'd10000000000;
      end
      return longint'(q);
   endfunction

   // expected heading of one point pair, with the same fixed-point angle path
   function automatic logic [HEAD_W-1:0] heading_of(input point_pair_type p);
      longint dx;
      longint dy;
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      longint q;
      dx = longint'(p.to_x) - longint'(p.from_x);
      dy = longint'(p.to_y) - longint'(p.from_y);
      if (dy == 0) begin
         return (dx < 0) ? HEAD_180 : HEAD_0;
      end
      if (dx == 0) begin
         return (dy > 0) ? HEAD_90 : HEAD_270;
      end
      // fold the left half plane onto the right one, starting from 180
      if (dx < 0) begin
         x = -dx;
         y = -dy;
         z = 180 * DEG_ONE;
      end else begin
         x = dx;
         y = dy;
         z = 0;
      end
      x = x * ANGLE_PRE;
      y = y * ANGLE_PRE;
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + cordic_step_angle(i);
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - cordic_step_angle(i);
         end
      end
      if (z < 0) z = z + 360 * DEG_ONE;
      if (z < 0) z = 0;
      q = (z + DEG_HALF) >>> FRAC_BITS;
      if (q > 360) q = 360;
      return HEAD_W'(q);
   endfunction

   // random pair, weighted toward the shapes that stress the angle path
   function automatic point_pair_type random_pair();
      point_pair_type p;
      int             d;
      logic [COORD_WIDTH-1:0] corners [5];
      corners = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
      p.from_x = COORD_WIDTH'($urandom());
      p.from_y = COORD_WIDTH'($urandom());
      p.to_x   = COORD_WIDTH'($urandom());
      p.to_y   = COORD_WIDTH'($urandom());
      case ($urandom_range(0, 9))
         4, 5: begin
            // short vectors, coarse angles
            p.to_x = COORD_WIDTH'(p.from_x + $urandom_range(0, 16) - 8);
            p.to_y = COORD_WIDTH'(p.from_y + $urandom_range(0, 16) - 8);
         end
         6: begin
            // close to one of the axes
            if ($urandom_range(0, 1) == 1) begin
               p.to_y = COORD_WIDTH'(p.from_y + $urandom_range(0, 4) - 2);
            end else begin
               p.to_x = COORD_WIDTH'(p.from_x + $urandom_range(0, 4) - 2);
            end
         end
         7: begin
            // exactly on an axis, or no vector at all
            case ($urandom_range(0, 2))
               0:       p.to_y = p.from_y;
               1:       p.to_x = p.from_x;
               default: begin
                  p.to_x = p.from_x;
                  p.to_y = p.from_y;
               end
            endcase
         end
         8: begin
            // near a diagonal
            d = $urandom_range(1, 16000);
            p.to_x = COORD_WIDTH'(p.from_x + (($urandom_range(0, 1) == 1) ? d : -d));
            p.to_y = COORD_WIDTH'(p.from_y + (($urandom_range(0, 1) == 1) ? d : -d)
                                  + $urandom_range(0, 6) - 3);
         end
         9: begin
            // corners and values around zero
            p.from_x = corners[$urandom_range(0, 4)];
            p.from_y = corners[$urandom_range(0, 4)];
            p.to_x   = corners[$urandom_range(0, 4)];
            p.to_y   = corners[$urandom_range(0, 4)];
         end
         default: ;
      endcase
      return p;
   endfunction

   // hold start low for the gap, then offer the beat until busy is low at an edge
   task automatic send_pair(input point_pair_type p, input logic [HEAD_W-1:0] want,
                            input int gap);
      bit taken;
      taken = 1'b0;
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start      <= 1'b1;
      req_from_x <= p.from_x;
      req_from_y <= p.from_y;
      req_to_x   <= p.to_x;
      req_to_y   <= p.to_y;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
      end
      pending_headings.push_back(want);
   endtask

   initial begin : stimulus
      point_pair_type pair;
      bit             burst;
      int             gap;
      reset      = 1'b1;
      start      = 1'b0;
      req_from_x = '0;
      req_from_y = '0;
      req_to_x   = '0;
      req_to_y   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows; obvious headings are typed in, the rest predicted
      foreach (directed_rows[r]) begin
         send_pair(directed_rows[r].pair,
                   directed_rows[r].fixed ? directed_rows[r].heading
                                          : heading_of(directed_rows[r].pair),
                   $urandom_range(0, MAX_GAP));
      end

      // random beats; some stretches run back to back with no gaps at all
      burst = 1'b0;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % BURST_LEN == 0) burst = ($urandom_range(0, 3) == 0);
         gap  = burst ? 0 : $urandom_range(0, MAX_GAP);
         pair = random_pair();
         send_pair(pair, heading_of(pair), gap);
      end
      @(negedge clock);
      start <= 1'b0;

      // drain the pipeline, then stay a little longer for stray strobes
      while (pending_headings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // result checker: every strobe must match the oldest owed heading
   always @(posedge clock) begin : heading_check
      logic [HEAD_W-1:0] want;
      if (!reset && rsp_valid) begin
         if (pending_headings.size() == 0) begin
            $error("rsp_heading_degrees: expected no beat, got %0d", rsp_heading_degrees);
            error_count++;
         end else begin
            want = pending_headings.pop_front();
            if (rsp_heading_degrees !== want) begin
               $error("rsp_heading_degrees: expected %0d, got %0d",
                      want, rsp_heading_degrees);
               error_count++;
            end
         end
      end
   end

   // hang detector: counts cycles with no beat accepted on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= HANG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

endmodule
